/* sv/lgf_pkg.sv */
// ----------------------------------------------------------------------------
// lgf_pkg
// types, constants and tables shared by the gap finder modules
// ----------------------------------------------------------------------------
package lgf_pkg;

  localparam int RANGE_W = 16;
  localparam int BEAM_W  = 12;
  localparam int WIN_W   = 11;
  localparam int COS_W   = 16;
  localparam int ANG_W   = 24;
  localparam int SQ_W    = 33;
  localparam int OUT_W   = 17;
  localparam int ZF_W    = 28;
  localparam int Z_W     = 39;
  localparam int XY_W    = 34;
  localparam int ATAN_N  = 28;

  localparam logic [26:0] TWO_PI_Q24  = 27'd105414357;
  localparam logic [26:0] PI_Q24      = 27'd52707179;
  localparam logic [26:0] HALF_PI_Q24 = 27'd26353589;
  localparam logic [15:0] GAIN_Q16    = 16'd39797;
  localparam logic [16:0] COORD_LIMIT = 17'd65535;

  localparam logic [23:0] ATAN_Q24 [ATAN_N] = '{
    24'd13176795, 24'd7778716, 24'd4110060, 24'd2086331, 24'd1047214, 24'd524117,
    24'd262123, 24'd131069, 24'd65536, 24'd32768, 24'd16384, 24'd8192, 24'd4096,
    24'd2048, 24'd1024, 24'd512, 24'd256, 24'd128, 24'd64, 24'd32, 24'd16, 24'd8,
    24'd4, 24'd2, 24'd1, 24'd0, 24'd0, 24'd0
  };

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_COS_STEP  = 3'd1,
    REG_ANG_STEP  = 3'd2,
    REG_WIN_FIRST = 3'd3,
    REG_WIN_LAST  = 3'd4,
    REG_AHEAD     = 3'd5
  } lgf_reg_e;

  typedef struct packed {
    logic [RANGE_W-1:0] threshold;
    logic [COS_W-1:0]   cos_step;
    logic [ANG_W-1:0]   ang_step;
    logic [WIN_W-1:0]   win_first;
    logic [WIN_W-1:0]   win_last;
    logic [WIN_W-1:0]   ahead;
  } lgf_cfg_t;

  typedef struct packed {
    logic               seen;
    logic [SQ_W-1:0]    sq;
    logic [RANGE_W-1:0] near;
    logic [RANGE_W-1:0] far;
    logic [BEAM_W-1:0]  beam;
  } lgf_job_t;

  typedef enum logic [2:0] {
    F_IDLE, F_M0, F_M1, F_M2, F_M3, F_SQ, F_UPD, F_PUSH
  } lgf_front_e;

  typedef enum logic [3:0] {
    B_IDLE, B_ANG, B_ABS, B_RED, B_FOLD, B_INIT, B_ROT, B_SQRT, B_NEG, B_CTR, B_DONE
  } lgf_back_e;

endpackage

/* sv/lgf_if.sv */
// ----------------------------------------------------------------------------
// lgf_if
// valid/ready channels for beam samples and gap results
// ----------------------------------------------------------------------------
interface lgf_beam_if;
  logic        valid;
  logic        ready;
  logic [15:0] range_mm;
  logic        last_beam;
  modport source (output valid, range_mm, last_beam, input ready);
  modport sink   (input valid, range_mm, last_beam, output ready);
endinterface

interface lgf_gap_if;
  logic               valid;
  logic               ready;
  logic               gap_found;
  logic [16:0]        gap_width_mm;
  logic signed [16:0] center_x_mm;
  logic signed [16:0] center_y_mm;
  modport source (output valid, gap_found, gap_width_mm, center_x_mm, center_y_mm,
                  input ready);
  modport sink   (input valid, gap_found, gap_width_mm, center_x_mm, center_y_mm,
                  output ready);
endinterface

/* sv/lidar_gap_finder_core.sv */
// ----------------------------------------------------------------------------
// lidar_gap_finder_core
// follow-the-gap detector: widest range jump of a lidar scan and its centre
// ----------------------------------------------------------------------------
// One range sample per beam transfer. A beam that forms no jump in the search
// window, unless it is the last, leaves the input ready for the next beam. A
// jump beam holds the input off through states M0 to M3, SQ and UPD, while one
// shared 32x16 multiplier forms a*a, b*b, a*b and the cosine product. On the
// last beam the scan summary goes into a two-entry queue from the PUSH state,
// which waits while the queue is full, and the back end works it out alone:
// range reduction and a cordic rotation for each end, an integer square root
// and setup states, so the next scan can stream in meanwhile. A scan with no
// jump goes straight to the result register with an all-zero result.
// Registers sit at byte address 4*i in the order threshold, cos step, angle
// step, window first, window last, ahead beam; writes must happen while idle,
// and the block itself does not enforce it.
// ----------------------------------------------------------------------------
module lidar_gap_finder_core
  import lgf_pkg::*;
#(
  parameter int MAX_BEAMS    = 2048,
  parameter int CORDIC_STEPS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  lgf_beam_if.sink    beam_i,
  lgf_gap_if.source   gap_o
);

  lgf_cfg_t   cfg_q;
  lgf_reg_e   reg_sel;
  logic       wr_en;
  logic       push, full, pop, empty;
  lgf_job_t   job_in, job_out;

  assign pready  = 1'b1;
  assign reg_sel = lgf_reg_e'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  // register file, reset to the default scan geometry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= 16'd500;
      cfg_q.cos_step  <= 16'd32767;
      cfg_q.ang_step  <= 24'd73205;
      cfg_q.win_first <= 11'd360;
      cfg_q.win_last  <= 11'd719;
      cfg_q.ahead     <= 11'd540;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_THRESHOLD: cfg_q.threshold <= pwdata[15:0];
        REG_COS_STEP:  cfg_q.cos_step  <= pwdata[15:0];
        REG_ANG_STEP:  cfg_q.ang_step  <= pwdata[23:0];
        REG_WIN_FIRST: cfg_q.win_first <= pwdata[10:0];
        REG_WIN_LAST:  cfg_q.win_last  <= pwdata[10:0];
        REG_AHEAD:     cfg_q.ahead     <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_THRESHOLD: prdata = 32'(cfg_q.threshold);
      REG_COS_STEP:  prdata = 32'(cfg_q.cos_step);
      REG_ANG_STEP:  prdata = 32'(cfg_q.ang_step);
      REG_WIN_FIRST: prdata = 32'(cfg_q.win_first);
      REG_WIN_LAST:  prdata = 32'(cfg_q.win_last);
      REG_AHEAD:     prdata = 32'(cfg_q.ahead);
      default:       prdata = '0;
    endcase
  end

  // per-beam front end: jump detection and best chord tracking
  lgf_front #(
    .MAX_BEAMS (MAX_BEAMS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .beam   (beam_i),
    .full_i (full),
    .push_o (push),
    .job_o  (job_in)
  );

  // scan summaries wait here for the geometry back end
  lgf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (job_out),
    .empty_o (empty)
  );

  // per-scan back end: width and centre, then the result register
  lgf_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .job_i   (job_out),
    .pop_o   (pop),
    .gap     (gap_o)
  );

endmodule

/* sv/lgf_front.sv */
// ----------------------------------------------------------------------------
// lgf_front
// beam counting, jump test, squared chord on a shared multiplier, best tracking
// ----------------------------------------------------------------------------
module lgf_front
  import lgf_pkg::*;
#(
  parameter int MAX_BEAMS = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  lgf_cfg_t   cfg_i,
  lgf_beam_if.sink   beam,
  input  logic       full_i,
  output logic       push_o,
  output lgf_job_t   job_o
);

  localparam int CW = $clog2(MAX_BEAMS);

  lgf_front_e         state_q, state_d;
  logic [RANGE_W-1:0] prev_q, a_q, b_q;
  logic [CW-1:0]      cnt_q;
  logic [BEAM_W-1:0]  first_q;
  logic               last_q;
  logic [47:0]        prod_q;
  logic [SQ_W-1:0]    acc_q, sq_q;
  lgf_job_t           best_q;

  logic               accept, jump, in_win;
  logic [BEAM_W-1:0]  first_w;
  logic [RANGE_W-1:0] diff;
  logic [31:0]        mul_a;
  logic [15:0]        mul_b;
  logic [47:0]        product;
  logic [SQ_W:0]      t_w;

  assign accept  = beam.valid && beam.ready;
  assign first_w = BEAM_W'(CW'(cnt_q - 1'b1));
  assign in_win  = (first_w >= BEAM_W'(cfg_i.win_first)) &&
                   (first_w <= BEAM_W'(cfg_i.win_last));
  assign diff    = (prev_q > beam.range_mm) ? prev_q - beam.range_mm
                                            : beam.range_mm - prev_q;
  assign jump    = (cnt_q != '0) && in_win && (diff > cfg_i.threshold);

  // operand select for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      F_M0: begin
        mul_a = 32'(a_q);
        mul_b = a_q;
      end
      F_M1: begin
        mul_a = 32'(b_q);
        mul_b = b_q;
      end
      F_M2: begin
        mul_a = 32'(a_q);
        mul_b = b_q;
      end
      F_M3: begin
        mul_a = prod_q[31:0];
        mul_b = cfg_i.cos_step;
      end
      default: ;
    endcase
  end

  assign product = mul_a * mul_b;
  assign t_w     = prod_q[47:14];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      F_IDLE: if (accept) state_d = jump ? F_M0 : (beam.last_beam ? F_PUSH : F_IDLE);
      F_M0:   state_d = F_M1;
      F_M1:   state_d = F_M2;
      F_M2:   state_d = F_M3;
      F_M3:   state_d = F_SQ;
      F_SQ:   state_d = F_UPD;
      F_UPD:  state_d = last_q ? F_PUSH : F_IDLE;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    beam.ready = (state_q == F_IDLE);
    push_o     = (state_q == F_PUSH) && !full_i;
    job_o      = best_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      prev_q  <= '0;
      cnt_q   <= '0;
      best_q  <= '0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        prev_q <= beam.range_mm;
        cnt_q  <= (cnt_q == CW'(MAX_BEAMS - 1)) ? '0 : cnt_q + 1'b1;
      end
      if (state_q == F_UPD && (!best_q.seen || sq_q > best_q.sq)) begin
        best_q.seen <= 1'b1;
        best_q.sq   <= sq_q;
        best_q.near <= a_q;
        best_q.far  <= b_q;
        best_q.beam <= first_q;
      end
      if (push_o) begin
        prev_q <= '0;
        cnt_q  <= '0;
        best_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q     <= prev_q;
      b_q     <= beam.range_mm;
      first_q <= first_w;
      last_q  <= beam.last_beam;
    end
    case (state_q)
      F_M0: prod_q <= product;
      F_M1: begin
        acc_q  <= prod_q[SQ_W-1:0];
        prod_q <= product;
      end
      F_M2: begin
        acc_q  <= acc_q + prod_q[SQ_W-1:0];
        prod_q <= product;
      end
      F_M3: prod_q <= product;
      F_SQ: sq_q <= ({1'b0, acc_q} > t_w) ? SQ_W'({1'b0, acc_q} - t_w) : '0;
      default: ;
    endcase
  end

endmodule

/* sv/lgf_queue.sv */
// ----------------------------------------------------------------------------
// lgf_queue
// two-entry job queue between the front and back parts
// ----------------------------------------------------------------------------
module lgf_queue
  import lgf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  lgf_job_t data_i,
  output logic     full_o,
  input  logic     pop_i,
  output lgf_job_t data_o,
  output logic     empty_o
);

  lgf_job_t   mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

endmodule

/* sv/lgf_back.sv */
// ----------------------------------------------------------------------------
// lgf_back
// angle reduction, cordic rotation, integer square root and result register
// ----------------------------------------------------------------------------
module lgf_back
  import lgf_pkg::*;
#(
  parameter int CORDIC_STEPS = 20
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lgf_cfg_t  cfg_i,
  input  logic      empty_i,
  input  lgf_job_t  job_i,
  output logic      pop_o,
  lgf_gap_if.source gap
);

  localparam int SW = $clog2(CORDIC_STEPS);

  lgf_back_e              state_q, state_d;
  lgf_job_t               job_q;
  logic                   phase_q, zneg_q, neg_q, neg1_q, load;
  logic signed [Z_W-1:0]  alpha_q;
  logic [Z_W-1:0]         mag_q;
  logic [3:0]             k_q;
  logic [26:0]            rr_q;
  logic signed [ZF_W-1:0] zr_q;
  logic signed [XY_W-1:0] x_q, y_q, c1_q, s1_q, c2_q, s2_q;
  logic [SW-1:0]          step_q;
  logic [SQ_W-1:0]        rem_q, bit_q;
  logic [SQ_W:0]          root_q;
  logic [OUT_W-1:0]       w_q;
  logic signed [OUT_W-1:0] cx_q, cy_q;

  logic                   out_valid_q, out_found_q;
  logic [OUT_W-1:0]       out_w_q;
  logic signed [OUT_W-1:0] out_x_q, out_y_q;

  // combinational datapath pieces
  logic signed [13:0]      beam_off;
  logic signed [Z_W-1:0]   z_w;
  logic [Z_W-1:0]          modulus;
  logic signed [ZF_W-1:0]  v_w, fold_w;
  logic                    fold_neg;
  logic [31:0]             gain_prod;
  logic [RANGE_W-1:0]      radius;
  logic signed [XY_W-1:0]  xs, ys, xn, yn;
  logic signed [ZF_W-1:0]  atan_w;
  logic [SQ_W:0]           trial;
  logic signed [XY_W:0]    sum_x, sum_y;
  logic signed [XY_W-15:0] pos_x, pos_y;
  logic                    last_step;

  assign beam_off = $signed({2'b0, job_q.beam}) - $signed({3'b0, cfg_i.ahead});
  assign z_w      = phase_q ? alpha_q + $signed({15'b0, cfg_i.ang_step}) : alpha_q;
  assign modulus  = Z_W'(TWO_PI_Q24) << k_q;

  // fold (-pi, pi] into [-pi/2, pi/2]
  always_comb begin
    v_w = (rr_q > PI_Q24) ? $signed({1'b0, rr_q}) - $signed({1'b0, TWO_PI_Q24})
                          : $signed({1'b0, rr_q});
    fold_w   = v_w;
    fold_neg = 1'b0;
    if (v_w > $signed({1'b0, HALF_PI_Q24})) begin
      fold_w   = v_w - $signed({1'b0, PI_Q24});
      fold_neg = 1'b1;
    end else if (v_w < -$signed({1'b0, HALF_PI_Q24})) begin
      fold_w   = v_w + $signed({1'b0, PI_Q24});
      fold_neg = 1'b1;
    end
  end

  assign radius    = phase_q ? job_q.far : job_q.near;
  assign gain_prod = radius * GAIN_Q16;

  assign xs        = x_q >>> step_q;
  assign ys        = y_q >>> step_q;
  assign xn        = (zr_q >= 0) ? x_q - ys : x_q + ys;
  assign yn        = (zr_q >= 0) ? y_q + xs : y_q - xs;
  assign atan_w    = $signed({4'b0, ATAN_Q24[5'(step_q)]});
  assign last_step = (step_q == SW'(CORDIC_STEPS - 1));

  assign trial = root_q + (SQ_W+1)'(bit_q);

  assign sum_x = XY_W'(c1_q) + c2_q + (XY_W+1)'(1 << 14);
  assign sum_y = XY_W'(s1_q) + s2_q + (XY_W+1)'(1 << 14);
  assign pos_x = sum_x[XY_W:15];
  assign pos_y = sum_y[XY_W:15];

  assign load = (state_q == B_DONE) && (!out_valid_q || gap.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: if (!empty_i) state_d = job_i.seen ? B_ANG : B_DONE;
      B_ANG:  state_d = B_ABS;
      B_ABS:  state_d = B_RED;
      B_RED:  if (k_q == 4'd0) state_d = B_FOLD;
      B_FOLD: state_d = B_INIT;
      B_INIT: state_d = B_ROT;
      B_ROT:  if (last_step) state_d = phase_q ? B_SQRT : B_ABS;
      B_SQRT: if (bit_q == SQ_W'(1)) state_d = B_NEG;
      B_NEG:  state_d = B_CTR;
      B_CTR:  state_d = B_DONE;
      B_DONE: if (load) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o            = (state_q == B_IDLE) && !empty_i;
    gap.valid        = out_valid_q;
    gap.gap_found    = out_found_q;
    gap.gap_width_mm = out_w_q;
    gap.center_x_mm  = out_x_q;
    gap.center_y_mm  = out_y_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load)           out_valid_q <= 1'b1;
      else if (gap.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        job_q   <= job_i;
        phase_q <= 1'b0;
        w_q     <= '0;
        cx_q    <= '0;
        cy_q    <= '0;
      end
      B_ANG: alpha_q <= Z_W'($signed({1'b0, cfg_i.ang_step}) * beam_off);
      B_ABS: begin
        zneg_q <= z_w[Z_W-1];
        mag_q  <= z_w[Z_W-1] ? Z_W'(-z_w) : Z_W'(z_w);
        k_q    <= 4'd11;
      end
      B_RED: begin
        if (mag_q >= modulus) mag_q <= mag_q - modulus;
        k_q <= k_q - 1'b1;
      end
      B_FOLD: rr_q <= (zneg_q && mag_q[26:0] != '0) ? TWO_PI_Q24 - mag_q[26:0]
                                                    : mag_q[26:0];
      B_INIT: begin
        zr_q   <= fold_w;
        neg_q  <= fold_neg;
        x_q    <= XY_W'(gain_prod >> 2);
        y_q    <= '0;
        step_q <= '0;
      end
      B_ROT: begin
        x_q    <= xn;
        y_q    <= yn;
        zr_q   <= (zr_q >= 0) ? zr_q - atan_w : zr_q + atan_w;
        step_q <= step_q + 1'b1;
        if (last_step) begin
          if (!phase_q) begin
            c1_q    <= xn;
            s1_q    <= yn;
            neg1_q  <= neg_q;
            phase_q <= 1'b1;
          end else begin
            c2_q   <= neg_q ? -xn : xn;
            s2_q   <= neg_q ? -yn : yn;
            rem_q  <= job_q.sq;
            root_q <= '0;
            bit_q  <= SQ_W'(1) << (SQ_W - 1);
          end
        end
      end
      B_SQRT: begin
        if ({1'b0, rem_q} >= trial) begin
          rem_q  <= SQ_W'({1'b0, rem_q} - trial);
          root_q <= (root_q >> 1) + (SQ_W+1)'(bit_q);
        end else begin
          root_q <= root_q >> 1;
        end
        bit_q <= bit_q >> 2;
      end
      B_NEG: begin
        if (neg1_q) begin
          c1_q <= -c1_q;
          s1_q <= -s1_q;
        end
      end
      B_CTR: begin
        w_q  <= root_q[OUT_W-1:0];
        cx_q <= (pos_x > $signed({1'b0, COORD_LIMIT})) ? $signed(COORD_LIMIT) :
                (pos_x < -$signed({1'b0, COORD_LIMIT})) ? -$signed(COORD_LIMIT) :
                OUT_W'(pos_x);
        cy_q <= (pos_y > $signed({1'b0, COORD_LIMIT})) ? $signed(COORD_LIMIT) :
                (pos_y < -$signed({1'b0, COORD_LIMIT})) ? -$signed(COORD_LIMIT) :
                OUT_W'(pos_y);
      end
      default: ;
    endcase
    if (load) begin
      out_found_q <= job_q.seen;
      out_w_q     <= w_q;
      out_x_q     <= cx_q;
      out_y_q     <= cy_q;
    end
  end

endmodule

/* verif/lidar_gap_finder_core_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lidar_gap_finder_core_test
// self-checking bench for the lidar gap finder core
// ----------------------------------------------------------------------------
// Beams go in through the beam channel and scan summaries come out of the gap
// channel. A behavioral model in this file follows every accepted beam, keeps
// the widest jump of the scan and, on the last beam, works out the gap width
// and centre with its own square root and cordic. Each summary is compared
// field by field with the oldest expected one. A short table of directed scans
// comes first, then random scans under several register settings, with random
// idling on both channels in most settings and two long hold-offs on the result side.
// ----------------------------------------------------------------------------
module lidar_gap_finder_core_test;
  import lgf_pkg::*;

  localparam int  STEPS      = 20;     // cordic steps of the default build
  localparam int  SCAN_WRAP  = 2048;   // beam counter modulus
  localparam int  SETTLE_CYC = 200;    // settle time for the back end
  localparam int  HOLD_CYC   = 300;    // long result stall

  // one scan summary as it leaves the block
  typedef struct {
    logic               found;
    logic [16:0]        width;
    logic signed [16:0] cx;
    logic signed [16:0] cy;
  } gap_t;

  // one row of the directed table
  typedef struct {
    logic [15:0] range_mm;
    logic        last;
    logic        typed;    // expectation typed in, else from the model
    gap_t        exp;
  } beam_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  lgf_beam_if beam_ch ();
  lgf_gap_if  gap_ch ();

  lidar_gap_finder_core uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .beam_i  (beam_ch.sink),
    .gap_o   (gap_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // register copy and per-scan state of the model
  longint thr, cos_q15, ang_q24, win_lo, win_hi, ahead;
  longint prev_rng, beam_idx, best_sq, best_near, best_far, best_first;
  bit     jump_seen;

  gap_t   pending_gaps[$];
  int     err_cnt = 0;
  int     beam_cnt = 0;
  int     gap_cnt = 0;
  int     setting_cnt = 0;
  bit     idling_on = 1'b1;   // random gaps on both channels
  bit     hold_req = 1'b0;    // asks the result side for one long stall

  // ---------------------------------------------------------------------------
  // model arithmetic
  // ---------------------------------------------------------------------------
  function automatic longint int_sqrt(longint v);
    longint root, bit_v;
    root = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > v) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (v >= root + bit_v) begin
        v = v - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return root;
  endfunction

  // r * (cos z, sin z) in Q14, z in Q24 radians
  task automatic cordic_polar(input longint r, input longint z,
                              output longint cx, output longint sy);
    longint x, y, nx;
    bit     flip;
    flip = 1'b0;
    z = z % longint'(TWO_PI_Q24);
    if (z < 0) z = z + longint'(TWO_PI_Q24);
    if (z > longint'(PI_Q24)) z = z - longint'(TWO_PI_Q24);
    // fold into the right half plane, remember the sign flip
    if (z > longint'(HALF_PI_Q24)) begin
      z = z - longint'(PI_Q24);
      flip = 1'b1;
    end else if (z < -longint'(HALF_PI_Q24)) begin
      z = z + longint'(PI_Q24);
      flip = 1'b1;
    end
    x = (r * longint'(GAIN_Q16)) >>> 2;
    y = 0;
    for (int k = 0; k < STEPS; k++) begin
      if (z >= 0) begin
        nx = x - (y >>> k);
        y = y + (x >>> k);
        z = z - longint'(ATAN_Q24[k]);
      end else begin
        nx = x + (y >>> k);
        y = y - (x >>> k);
        z = z + longint'(ATAN_Q24[k]);
      end
      x = nx;
    end
    cx = flip ? -x : x;
    sy = flip ? -y : y;
  endtask

  function automatic logic signed [16:0] mid_coord(longint p, longint q);
    longint v;
    v = (p + q + (longint'(1) << 14)) >>> 15;
    if (v > 65535) v = 65535;
    if (v < -65535) v = -65535;
    return v[16:0];
  endfunction

  function automatic void clear_scan();
    prev_rng = 0;
    beam_idx = 0;
    best_sq = 0;
    best_near = 0;
    best_far = 0;
    best_first = 0;
    jump_seen = 1'b0;
  endfunction

  // follows one beam; returns 1 with the summary on the last beam of a scan
  task automatic track_beam(input logic [15:0] rng, input logic last,
                            output bit has_gap, output gap_t g);
    longint a, b, d, ab, t, s, sq, alpha, c1, s1, c2, s2;
    b = rng;
    has_gap = 1'b0;
    g = '{1'b0, '0, '0, '0};
    if (beam_idx >= 1) begin
      a = prev_rng;
      d = (a > b) ? a - b : b - a;
      if (beam_idx - 1 >= win_lo && beam_idx - 1 <= win_hi && d > thr) begin
        ab = a * b;
        t = 2 * ((ab >> 15) * cos_q15) + (((ab & 'h7FFF) * cos_q15 * 2) >> 15);
        s = a * a + b * b;
        sq = (s > t) ? s - t : 0;
        // on a tie the earlier jump stays
        if (!jump_seen || sq > best_sq) begin
          best_sq = sq;
          best_near = a;
          best_far = b;
          best_first = beam_idx - 1;
          jump_seen = 1'b1;
        end
      end
    end
    prev_rng = b;
    beam_idx = (beam_idx + 1) % SCAN_WRAP;
    if (last) begin
      has_gap = 1'b1;
      if (jump_seen) begin
        alpha = ang_q24 * (best_first - ahead);
        cordic_polar(best_near, alpha, c1, s1);
        cordic_polar(best_far, alpha + ang_q24, c2, s2);
        g.found = 1'b1;
        g.width = 17'(int_sqrt(best_sq));
        g.cx = mid_coord(c1, c2);
        g.cy = mid_coord(s1, s2);
      end
      clear_scan();
    end
  endtask

  // ---------------------------------------------------------------------------
  // configuration port
  // ---------------------------------------------------------------------------
  task automatic write_reg(input lgf_reg_e idx, input longint val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val[31:0];
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr = val & 'hFFFF;
      REG_COS_STEP:  cos_q15 = val & 'hFFFF;
      REG_ANG_STEP:  ang_q24 = val & 'hFFFFFF;
      REG_WIN_FIRST: win_lo = val & 'h7FF;
      REG_WIN_LAST:  win_hi = val & 'h7FF;
      REG_AHEAD:     ahead = val & 'h7FF;
      default: ;
    endcase
  endtask

  task automatic load_setting(input longint t, input longint c, input longint ang,
                              input longint lo, input longint hi, input longint ah);
    write_reg(REG_THRESHOLD, t);
    write_reg(REG_COS_STEP, c);
    write_reg(REG_ANG_STEP, ang);
    write_reg(REG_WIN_FIRST, lo);
    write_reg(REG_WIN_LAST, hi);
    write_reg(REG_AHEAD, ah);
    setting_cnt++;
  endtask

  // let all results drain, then the back end settle, before touching registers
  task automatic drain();
    while (pending_gaps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // beam sender: ends at a falling edge with valid still high
  // ---------------------------------------------------------------------------
  task automatic send_beam(input logic [15:0] rng, input logic last,
                           input logic typed, input gap_t typed_exp);
    int   gap_cyc;
    bit   has_gap;
    gap_t g;
    track_beam(rng, last, has_gap, g);
    if (has_gap) pending_gaps.push_back(typed ? typed_exp : g);
    gap_cyc = idling_on ? $urandom_range(0, 6) : 0;
    if (gap_cyc > 0) begin
      beam_ch.valid <= 1'b0;
      repeat (gap_cyc) @(negedge clk_i);
    end
    beam_ch.valid <= 1'b1;
    beam_ch.range_mm <= rng;
    beam_ch.last_beam <= last;
    @(posedge clk_i);
    while (!beam_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    beam_cnt++;
  endtask

  // small steps from the last range, random ranges up to 8000, raw noise and extremes
  function automatic logic [15:0] pick_range(logic [15:0] prev);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 16'hFFFF;
      1: return 16'h0000;
      2, 3: return prev + 16'($urandom_range(0, 700)) - 16'd350;
      4, 5: return 16'($urandom_range(0, 8000));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_scans(input int n_beams, input int max_len);
    int          len;
    logic [15:0] r;
    gap_t        none;
    none = '{1'b0, '0, '0, '0};
    r = 16'd1000;
    while (n_beams > 0) begin
      len = $urandom_range(1, max_len);
      for (int i = 0; i < len; i++) begin
        r = pick_range(r);
        send_beam(r, i == len - 1, 1'b0, none);
      end
      n_beams -= len;
    end
  endtask

  // directed scans: single beam, extremes, tie, no jump, threshold edge
  localparam gap_t NO_GAP = '{1'b0, 17'd0, 17'sd0, 17'sd0};
  beam_row_t beam_table [13] = '{
    '{16'd0,     1'b1, 1'b1, NO_GAP},
    '{16'd0,     1'b0, 1'b0, NO_GAP},
    '{16'd65535, 1'b1, 1'b0, NO_GAP},
    '{16'd65535, 1'b0, 1'b0, NO_GAP},
    '{16'd0,     1'b1, 1'b0, NO_GAP},
    '{16'd0,     1'b0, 1'b0, NO_GAP},
    '{16'd1000,  1'b0, 1'b0, NO_GAP},
    '{16'd0,     1'b1, 1'b0, NO_GAP},
    '{16'd100,   1'b0, 1'b0, NO_GAP},
    '{16'd100,   1'b0, 1'b0, NO_GAP},
    '{16'd100,   1'b1, 1'b1, NO_GAP},
    '{16'd40000, 1'b0, 1'b0, NO_GAP},
    '{16'd40500, 1'b1, 1'b0, NO_GAP}
  };

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  initial begin
    beam_ch.valid = 1'b0;
    beam_ch.range_mm = '0;
    beam_ch.last_beam = 1'b0;
    thr = 500; cos_q15 = 32767; ang_q24 = 73205;
    win_lo = 360; win_hi = 719; ahead = 540;
    clear_scan();
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // small window so short scans reach it
    load_setting(500, 32767, 73205, 0, 20, 10);
    foreach (beam_table[i])
      send_beam(beam_table[i].range_mm, beam_table[i].last,
                beam_table[i].typed, beam_table[i].exp);
    random_scans(100, 24);
    beam_ch.valid <= 1'b0;
    drain();

    // every pair searched, zero threshold and angle, no idling
    idling_on = 1'b0;
    load_setting(0, 0, 0, 0, 2047, 0);
    random_scans(100, 24);
    beam_ch.valid <= 1'b0;
    drain();

    // largest threshold: no jump can pass; result side holds off for a while
    idling_on = 1'b1;
    load_setting(65535, 32768, 16777215, 3, 15, 2047);
    hold_req = 1'b1;
    random_scans(100, 6);
    beam_ch.valid <= 1'b0;
    drain();

    // inverted window, cosine above one
    load_setting(100, 65535, 1000000, 5, 4, 7);
    random_scans(60, 12);
    beam_ch.valid <= 1'b0;
    drain();

    // single searched pair, cosine above one clamps the square
    load_setting(1000, 65535, 8388608, 2, 2, 0);
    random_scans(80, 10);
    beam_ch.valid <= 1'b0;
    drain();

    // single pair again with long short-scan pressure on the result side
    load_setting(1000, 30000, 8388608, 2, 2, 2047);
    hold_req = 1'b1;
    random_scans(80, 4);
    beam_ch.valid <= 1'b0;
    drain();

    // window at the top of the beam range, out of reach of short scans
    load_setting(300, 16384, 200000, 2040, 2047, 1024);
    random_scans(80, 16);
    beam_ch.valid <= 1'b0;

    while (pending_gaps.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    $display("run covered %0d beams and %0d scan results under %0d register settings",
             beam_cnt, gap_cnt, setting_cnt);
    if (err_cnt == 0) begin
      $display("** lidar_gap_finder_core: PASSED **");
    end else begin
      $display("** lidar_gap_finder_core: FAILED **");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // result receiver and checker
  // ---------------------------------------------------------------------------
  initial begin
    int   stall;
    gap_t g;
    gap_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        // long stall so the block queue fills and the beam input backs up
        hold_req = 1'b0;
        gap_ch.ready <= 1'b0;
        repeat (HOLD_CYC) @(negedge clk_i);
      end
      stall = idling_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        gap_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      gap_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!gap_ch.valid) @(posedge clk_i);
      gap_cnt++;
      if (pending_gaps.size() == 0) begin
        $error("unexpected result transfer");
        err_cnt++;
      end else begin
        g = pending_gaps.pop_front();
        if (gap_ch.gap_found !== g.found) begin
          $error("gap_found: expected %0d, got %0d", g.found, gap_ch.gap_found);
          err_cnt++;
        end
        if (gap_ch.gap_width_mm !== g.width) begin
          $error("gap_width_mm: expected %0d, got %0d", g.width, gap_ch.gap_width_mm);
          err_cnt++;
        end
        if (gap_ch.center_x_mm !== g.cx) begin
          $error("center_x_mm: expected %0d, got %0d", g.cx, gap_ch.center_x_mm);
          err_cnt++;
        end
        if (gap_ch.center_y_mm !== g.cy) begin
          $error("center_y_mm: expected %0d, got %0d", g.cy, gap_ch.center_y_mm);
          err_cnt++;
        end
      end
    end
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d results outstanding", pending_gaps.size());
    $display("** lidar_gap_finder_core: FAILED **");
    $finish;
  end

endmodule
